// File: sv/fcla_pkg.sv
// Shared constants, types and tables for the FCC lattice axis query pipeline.
// Holds the neighbour offset table, the reciprocal table and the beat structs.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fcla_pkg;

  localparam int COORD_BITS = 16;
  localparam int NUM_DIRS   = 12;
  localparam int ROM_DEPTH  = 72;
  localparam int ROM_IDX_W  = 7;
  localparam int DIR_W      = 4;
  localparam int LEN_W      = 18;

  // Offset site index for the mod-3 reduction: z + 3*2^(COORD_BITS-1) is never negative.
  localparam int ZU_W = COORD_BITS + 1;
  localparam logic [ZU_W-1:0] MOD3_OFFSET = ZU_W'(3 * (1 << (COORD_BITS - 1)));
  localparam logic [ZU_W-1:0] MOD3_RECIP  = ZU_W'((1 << ZU_W) / 3);

  // Cartesian coordinates (sixths of the lattice spacing) and their differences.
  localparam int V_W     = COORD_BITS + 4;
  localparam int W_W     = 5;
  localparam int DOT_W   = V_W + W_W + 2;
  localparam int DIV_W   = 4;
  localparam int RECIP_W = V_W + 1;

  localparam logic signed [V_W-1:0] CART_THREE = V_W'(3);

  typedef logic [DIR_W-1:0] dir_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } site_t;

  typedef struct packed {
    logic signed [W_W-1:0] x;
    logic signed [W_W-1:0] y;
    logic signed [W_W-1:0] z;
  } wvec_t;

  typedef struct packed {
    logic signed [V_W-1:0] x;
    logic signed [V_W-1:0] y;
    logic signed [V_W-1:0] z;
  } vvec_t;

  // Displacement and the first site's stacking class, as left by the front end.
  typedef struct packed {
    vvec_t      v;
    logic       ypar;
    logic [1:0] zm;
  } cart_beat_t;

  // Chosen direction and the operands of the step count division.
  typedef struct packed {
    logic                 found;
    dir_t                 dir;
    logic [V_W-1:0]       num;
    logic [DIV_W-1:0]     den;
    logic [RECIP_W-1:0]   recip;
  } sel_beat_t;

  function automatic logic [5:0] nb_enc(int a, int b, int c);
    return {c[1:0], b[1:0], a[1:0]};
  endfunction

  // Entry (ypar*3 + zmod)*12 + dir: dx in bits 1:0, dy in 3:2, dz in 5:4.
  localparam logic [5:0] NB_ROM [ROM_DEPTH] = '{
    nb_enc(0,-1,-1), nb_enc(1,-1,-1), nb_enc(0,0,-1), nb_enc(0,-1,0), nb_enc(1,-1,0),
    nb_enc(-1,0,0), nb_enc(1,0,0), nb_enc(0,1,0), nb_enc(1,1,0), nb_enc(0,-1,1),
    nb_enc(-1,0,1), nb_enc(0,0,1),
    nb_enc(0,0,-1), nb_enc(1,0,-1), nb_enc(1,1,-1), nb_enc(0,-1,0), nb_enc(1,-1,0),
    nb_enc(-1,0,0), nb_enc(1,0,0), nb_enc(0,1,0), nb_enc(1,1,0), nb_enc(1,-1,1),
    nb_enc(0,0,1), nb_enc(1,0,1),
    nb_enc(-1,0,-1), nb_enc(0,0,-1), nb_enc(0,1,-1), nb_enc(0,-1,0), nb_enc(1,-1,0),
    nb_enc(-1,0,0), nb_enc(1,0,0), nb_enc(0,1,0), nb_enc(1,1,0), nb_enc(0,0,1),
    nb_enc(0,1,1), nb_enc(1,1,1),
    nb_enc(-1,-1,-1), nb_enc(0,-1,-1), nb_enc(0,0,-1), nb_enc(-1,-1,0), nb_enc(0,-1,0),
    nb_enc(-1,0,0), nb_enc(1,0,0), nb_enc(-1,1,0), nb_enc(0,1,0), nb_enc(-1,-1,1),
    nb_enc(-1,0,1), nb_enc(0,0,1),
    nb_enc(0,0,-1), nb_enc(1,0,-1), nb_enc(0,1,-1), nb_enc(-1,-1,0), nb_enc(0,-1,0),
    nb_enc(-1,0,0), nb_enc(1,0,0), nb_enc(-1,1,0), nb_enc(0,1,0), nb_enc(0,-1,1),
    nb_enc(0,0,1), nb_enc(1,0,1),
    nb_enc(-1,0,-1), nb_enc(0,0,-1), nb_enc(-1,1,-1), nb_enc(-1,-1,0), nb_enc(0,-1,0),
    nb_enc(-1,0,0), nb_enc(1,0,0), nb_enc(-1,1,0), nb_enc(0,1,0), nb_enc(0,0,1),
    nb_enc(-1,1,1), nb_enc(0,1,1)
  };

  // floor(2^V_W / d) for the divisors that occur; entry 0 is unused.
  localparam logic [RECIP_W-1:0] RECIP_ROM [16] = '{
    RECIP_W'(0),
    RECIP_W'((1 << V_W) / 1),  RECIP_W'((1 << V_W) / 2),  RECIP_W'((1 << V_W) / 3),
    RECIP_W'((1 << V_W) / 4),  RECIP_W'((1 << V_W) / 5),  RECIP_W'((1 << V_W) / 6),
    RECIP_W'((1 << V_W) / 7),  RECIP_W'((1 << V_W) / 8),  RECIP_W'((1 << V_W) / 9),
    RECIP_W'((1 << V_W) / 10), RECIP_W'((1 << V_W) / 11), RECIP_W'((1 << V_W) / 12),
    RECIP_W'((1 << V_W) / 13), RECIP_W'((1 << V_W) / 14), RECIP_W'((1 << V_W) / 15)
  };

  // Cartesian displacement to the neighbour in direction dir, for a first site of
  // the given y parity and z mod 3. It depends on nothing else.
  function automatic wvec_t nb_w(logic ypar, logic [1:0] zm, dir_t dir);
    logic [ROM_IDX_W-1:0] idx;
    logic [5:0]           e;
    int                   dx, dy, dz, yi, zi, yp_n, zsum, zm_n, wx, wy, wz;
    wvec_t                w;
    idx  = ROM_IDX_W'((int'(ypar) * 3 + int'(zm)) * NUM_DIRS + int'(dir));
    e    = (idx < ROM_IDX_W'(ROM_DEPTH)) ? NB_ROM[idx] : 6'd0;
    dx   = int'($signed(e[1:0]));
    dy   = int'($signed(e[3:2]));
    dz   = int'($signed(e[5:4]));
    yi   = int'(ypar);
    zi   = int'(zm);
    yp_n = yi ^ int'(e[2]);
    zsum = zi + dz;
    zm_n = (zsum < 0) ? zsum + 3 : ((zsum > 2) ? zsum - 3 : zsum);
    wx   = 6 * dx - 3 * yp_n + 3 * yi + ((zm_n == 1) ? 3 : 0) - ((zi == 1) ? 3 : 0);
    wy   = 6 * dy + 2 * zm_n - 2 * zi;
    wz   = 6 * dz;
    w.x  = W_W'(wx);
    w.y  = W_W'(wy);
    w.z  = W_W'(wz);
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/fcla_if.sv
// Valid/ready channel interfaces for the query beats and the result beats.
// Depends on fcla_pkg for the coordinate and field widths.
`default_nettype none

interface fcla_in_if import fcla_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t from_x;
  coord_t from_y;
  coord_t from_z;
  coord_t to_x;
  coord_t to_y;
  coord_t to_z;

  modport source(output valid, output from_x, output from_y, output from_z,
                 output to_x, output to_y, output to_z, input ready);
  modport sink(input valid, input from_x, input from_y, input from_z,
               input to_x, input to_y, input to_z, output ready);
endinterface

interface fcla_out_if import fcla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  dir_t             direction;
  logic [LEN_W-1:0] step_count;

  modport source(output valid, output found, output direction, output step_count,
                 input ready);
  modport sink(input valid, input found, input direction, input step_count,
               output ready);
endinterface

`default_nettype wire

// File: sv/fcla_cart.sv
// Front end: input register, mod-3 reduction of z and cartesian displacement.
// Depends on fcla_pkg and fcla_in_if; feeds fcla_match.
`default_nettype none

module fcla_cart import fcla_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  fcla_in_if.sink     req,
  output cart_beat_t  out_beat,
  output logic        out_valid,
  input  wire logic   out_ready
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  site_t            a1, b1, a2, b2;
  logic [ZU_W-1:0]  zu_a2, zu_b2, zq_a2, zq_b2;
  cart_beat_t       c3;

  logic [ZU_W-1:0]    zu_a, zu_b;
  logic [2*ZU_W-1:0]  prod_a, prod_b;
  logic [ZU_W-1:0]    r_a, r_b;
  logic [1:0]         zm_a, zm_b;
  logic signed [V_W-1:0] xa, ya, za, xb, yb, zb;
  logic signed [V_W-1:0] qxa, qya, qza, qxb, qyb, qzb;
  cart_beat_t         c_next;

  assign en3       = !v3 || out_ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req.ready = en1;
  assign out_valid = v3;
  assign out_beat  = c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Quotient estimate of zu / 3; it is the true quotient or one less.
  always_comb begin
    zu_a   = ZU_W'(a1.z) + MOD3_OFFSET;
    zu_b   = ZU_W'(b1.z) + MOD3_OFFSET;
    prod_a = (2*ZU_W)'(zu_a) * (2*ZU_W)'(MOD3_RECIP);
    prod_b = (2*ZU_W)'(zu_b) * (2*ZU_W)'(MOD3_RECIP);
  end

  always_comb begin
    r_a  = zu_a2 - (zq_a2 << 1) - zq_a2;
    r_b  = zu_b2 - (zq_b2 << 1) - zq_b2;
    zm_a = (r_a[2:0] >= 3'd3) ? 2'(r_a[2:0] - 3'd3) : r_a[1:0];
    zm_b = (r_b[2:0] >= 3'd3) ? 2'(r_b[2:0] - 3'd3) : r_b[1:0];

    xa = V_W'(a2.x);
    ya = V_W'(a2.y);
    za = V_W'(a2.z);
    xb = V_W'(b2.x);
    yb = V_W'(b2.y);
    zb = V_W'(b2.z);

    qxa = (xa <<< 2) + (xa <<< 1);
    if (a2.y[0]) qxa = qxa - CART_THREE;
    if (zm_a == 2'd1) qxa = qxa + CART_THREE;
    qya = (ya <<< 2) + (ya <<< 1) + $signed(V_W'({zm_a, 1'b0}));
    qza = (za <<< 2) + (za <<< 1);

    qxb = (xb <<< 2) + (xb <<< 1);
    if (b2.y[0]) qxb = qxb - CART_THREE;
    if (zm_b == 2'd1) qxb = qxb + CART_THREE;
    qyb = (yb <<< 2) + (yb <<< 1) + $signed(V_W'({zm_b, 1'b0}));
    qzb = (zb <<< 2) + (zb <<< 1);

    c_next.v.x  = qxb - qxa;
    c_next.v.y  = qyb - qya;
    c_next.v.z  = qzb - qza;
    c_next.ypar = a2.y[0];
    c_next.zm   = zm_a;
  end

  always_ff @(posedge clk) begin
    if (en1 && req.valid) begin
      a1 <= '{x: req.from_x, y: req.from_y, z: req.from_z};
      b1 <= '{x: req.to_x, y: req.to_y, z: req.to_z};
    end
    if (en2 && v1) begin
      a2    <= a1;
      b2    <= b1;
      zu_a2 <= zu_a;
      zu_b2 <= zu_b;
      zq_a2 <= prod_a[2*ZU_W-1:ZU_W];
      zq_b2 <= prod_b[2*ZU_W-1:ZU_W];
    end
    if (en3 && v2) begin
      c3 <= c_next;
    end
  end

  a_zm_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (c3.zm != 2'd3))
    else $error("z mod 3 left outside 0..2");

endmodule

`default_nettype wire

// File: sv/fcla_match.sv
// Direction test: parallelism check against all twelve neighbour directions,
// then selection of the first match and of the division operands.
// Depends on fcla_pkg; sits between fcla_cart and fcla_div.
`default_nettype none

module fcla_match import fcla_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cart_beat_t  in_beat,
  input  wire logic        in_valid,
  output logic             in_ready,
  output sel_beat_t        out_beat,
  output logic             out_valid,
  input  wire logic        out_ready
);

  logic v4, v5;
  logic en4, en5;

  logic [NUM_DIRS-1:0] m4, m_next;
  cart_beat_t          c4;
  sel_beat_t           s5, s_next;

  assign en5       = !v5 || out_ready;
  assign en4       = !v4 || en5;
  assign in_ready  = en4;
  assign out_valid = v5;
  assign out_beat  = s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
    end
  end

  // w and v are positively parallel when the cross product vanishes and the dot
  // product is positive.
  always_comb begin
    wvec_t                   w;
    logic signed [DOT_W-1:0] wx, wy, wz, vx, vy, vz, dot, c0, c1, c2;
    for (int d = 0; d < NUM_DIRS; d++) begin
      w   = nb_w(in_beat.ypar, in_beat.zm, DIR_W'(d));
      wx  = DOT_W'(w.x);
      wy  = DOT_W'(w.y);
      wz  = DOT_W'(w.z);
      vx  = DOT_W'(in_beat.v.x);
      vy  = DOT_W'(in_beat.v.y);
      vz  = DOT_W'(in_beat.v.z);
      dot = wx * vx + wy * vy + wz * vz;
      c0  = wy * vz - wz * vy;
      c1  = wz * vx - wx * vz;
      c2  = wx * vy - wy * vx;
      m_next[d] = (c0 == '0) && (c1 == '0) && (c2 == '0) &&
                  !dot[DOT_W-1] && (dot != '0);
    end
  end

  // Lowest matching direction wins; the step count divides by the first
  // non-zero component of its displacement.
  always_comb begin
    wvec_t                 w;
    logic signed [V_W-1:0] nv;
    logic signed [W_W-1:0] dw;
    logic [W_W-1:0]        dmag;
    s_next.found = 1'b0;
    s_next.dir   = '0;
    for (int d = NUM_DIRS - 1; d >= 0; d--) begin
      if (m4[d]) begin
        s_next.found = 1'b1;
        s_next.dir   = DIR_W'(d);
      end
    end
    w = nb_w(c4.ypar, c4.zm, s_next.dir);
    if (w.x != '0) begin
      nv = c4.v.x;
      dw = w.x;
    end else if (w.y != '0) begin
      nv = c4.v.y;
      dw = w.y;
    end else begin
      nv = c4.v.z;
      dw = w.z;
    end
    dmag         = dw[W_W-1] ? W_W'(-dw) : W_W'(dw);
    s_next.den   = dmag[DIV_W-1:0];
    s_next.num   = !s_next.found ? '0 : (nv[V_W-1] ? V_W'(-nv) : V_W'(nv));
    s_next.recip = RECIP_ROM[s_next.den];
  end

  always_ff @(posedge clk) begin
    if (en4 && in_valid) begin
      c4 <= in_beat;
      m4 <= m_next;
    end
    if (en5 && v4) begin
      s5 <= s_next;
    end
  end

  a_sel_sane: assert property (@(posedge clk) disable iff (rst)
    (v5 && s5.found) |-> ((s5.den != '0) && (s5.dir < DIR_W'(NUM_DIRS))))
    else $error("matched direction has no usable divisor");

endmodule

`default_nettype wire

// File: sv/fcla_div.sv
// Back end: step count by reciprocal multiply with one correction step, and the
// result register that drives the output channel.
// Depends on fcla_pkg and fcla_out_if; fed by fcla_match.
`default_nettype none

module fcla_div import fcla_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire sel_beat_t  in_beat,
  input  wire logic       in_valid,
  output logic            in_ready,
  fcla_out_if.source      rsp
);

  logic v6, v7;
  logic en6, en7;

  logic               f6;
  dir_t               dir6;
  logic [V_W-1:0]     num6, q6;
  logic [DIV_W-1:0]   den6;

  logic               f7;
  dir_t               dir7;
  logic [LEN_W-1:0]   len7;

  logic [2*V_W:0]       prod;
  logic [V_W+DIV_W-1:0] qd;
  logic [V_W:0]         rem, twice_den;
  logic [V_W-1:0]       q_fix;

  assign en7       = !v7 || rsp.ready;
  assign en6       = !v6 || en7;
  assign in_ready  = en6;

  assign rsp.valid      = v7;
  assign rsp.found      = f7;
  assign rsp.direction  = dir7;
  assign rsp.step_count = len7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en6) v6 <= in_valid;
      if (en7) v7 <= v6;
    end
  end

  // The estimate is the true quotient or one less, so the remainder is below
  // twice the divisor and one compare settles it.
  always_comb begin
    prod      = (2*V_W+1)'(in_beat.num) * (2*V_W+1)'(in_beat.recip);
    qd        = (V_W+DIV_W)'(q6) * (V_W+DIV_W)'(den6);
    rem       = {1'b0, num6} - qd[V_W:0];
    twice_den = (V_W+1)'({den6, 1'b0});
    q_fix     = (rem >= (V_W+1)'(den6)) ? q6 + V_W'(1) : q6;
  end

  always_ff @(posedge clk) begin
    if (en6 && in_valid) begin
      f6   <= in_beat.found;
      dir6 <= in_beat.dir;
      num6 <= in_beat.num;
      den6 <= in_beat.den;
      q6   <= prod[2*V_W-1:V_W];
    end
    if (en7 && v6) begin
      f7   <= f6;
      dir7 <= f6 ? dir6 : '0;
      len7 <= f6 ? LEN_W'(q_fix) : '0;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v6 |-> (rem < twice_den))
    else $error("reciprocal quotient estimate off by more than one");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (v7 && !f7) |-> ((dir7 == '0) && (len7 == '0)))
    else $error("miss result carries a direction or step count");

endmodule

`default_nettype wire

// File: sv/fcc_lattice_axis_direction_length.sv
// Top level of the FCC lattice axis query: front end, direction test and step
// count back end joined by valid/ready links. Depends on fcla_pkg, fcla_if,
// fcla_cart, fcla_match and fcla_div.
`default_nettype none

// A query beat on req carries two site indices of a face-centred-cubic lattice
// with ABC stacking; the matching beat on rsp says whether the second site lies
// on one of the twelve nearest-neighbour axes from the first, in the positive
// sense, and if so gives the lowest such direction and the number of steps. Equal
// sites and sites off every axis give found, direction and step_count all zero.
// The block is a seven-stage pipeline that takes one query beat in every clock
// cycle when rsp is not stalled and returns the results in order. The stage cut
// follows the multipliers: the reduction of z modulo 3 by a reciprocal product,
// the cartesian displacement, the twelve parallel cross and dot product tests,
// the priority pick of the first matching direction, the reciprocal product for
// the step count and its correction step. Every stage holds its beat while the
// one after it is full, so a stall on rsp neither drops nor repeats a beat, and
// empty stages are filled while a finished result still waits at the output
// register. The block has no configuration and no state beyond the pipeline
// itself; its neighbour offset and reciprocal tables are constant logic.
module fcc_lattice_axis_direction_length import fcla_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  fcla_in_if.sink    req,
  fcla_out_if.source rsp
);

  cart_beat_t cart_beat;
  logic       cart_valid;
  logic       cart_ready;

  sel_beat_t  sel_beat;
  logic       sel_valid;
  logic       sel_ready;

  fcla_cart u_cart (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_beat  (cart_beat),
    .out_valid (cart_valid),
    .out_ready (cart_ready)
  );

  fcla_match u_match (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (cart_beat),
    .in_valid  (cart_valid),
    .in_ready  (cart_ready),
    .out_beat  (sel_beat),
    .out_valid (sel_valid),
    .out_ready (sel_ready)
  );

  fcla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (sel_beat),
    .in_valid (sel_valid),
    .in_ready (sel_ready),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
